FILE: hw/rtl/tpsp_pkg.sv
// Trim path segment planner: shared widths, register indexes and op codes.
// No dependencies; used by tpsp_mul and the top level.
package tpsp_pkg;

  localparam int LEN_W  = 20;   // contour length, Q12.8
  localparam int FRAC_W = 17;   // trim fractions, Q0.16 with room for 1.0
  localparam int OFF_W  = 16;   // used part of the offset
  localparam int DIST_W = 25;   // segment distances, Q17.8
  localparam int OUT_CI_W = 4;  // contour index as presented on the port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic [2:0] REG_TRIM_START  = 3'd0;
  localparam logic [2:0] REG_TRIM_END    = 3'd1;
  localparam logic [2:0] REG_TRIM_OFFSET = 3'd2;
  localparam logic [2:0] REG_TRIM_MODE   = 3'd3;
  localparam logic [2:0] REG_CLOSE_ALL   = 3'd4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic MODE_SEQ = 1'b0;

endpackage

FILE: hw/rtl/tpsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hw/rtl/tpsp_mul.sv
// Shared scaling unit: length times (fraction + offset fraction), Q.8 result.
// Depends on tpsp_pkg; the product is registered.
module tpsp_mul #(
  parameter int A_W = 25
) (
  input  logic                       clk,
  input  logic [A_W-1:0]             a,
  input  logic [tpsp_pkg::FRAC_W-1:0] frac,
  input  logic [tpsp_pkg::OFF_W-1:0]  off,
  output logic [A_W+1:0]             q
);

  localparam int F_W = tpsp_pkg::FRAC_W + 1;

  logic [F_W-1:0]     f;
  logic [A_W+F_W-1:0] prod_r;

  assign f = F_W'(frac) + F_W'(off);

  always_ff @(posedge clk) begin
    prod_r <= (A_W+F_W)'(a) * (A_W+F_W)'(f);
  end

  // floor(prod / 65536)
  assign q = prod_r[A_W+F_W-1:16];

endmodule

FILE: hw/rtl/trim_path_segment_planner_top.sv
// Trim path segment planner top level: APB register file, contour store,
// sequencer around the shared scaling unit, segment plan RAM, result register.
// Depends on tpsp_pkg, tpsp_mul and tpsp_ram.
//
// Clear and add are handled in idle. A sequential run sums the contour
// lengths (one per cycle), scales start and end through the one shared
// multiplier, then swaps and wraps them, then walks the contours one per
// cycle until the window is used up or the plan is full, writing each segment
// to the plan RAM. Synchronized mode scales, swaps and wraps per contour with
// that contour's length and writes one segment per wrap. Results then leave
// one at a time (plan RAM read, load, transfer, held while out_stall is high);
// the block takes no new item until the last result of a run is transferred.
module trim_path_segment_planner_top #(
  parameter int MAX_CONTOURS = 16,
  parameter int MAX_SEGMENTS = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [tpsp_pkg::LEN_W-1:0]    in_contour_length,
  input  logic                          in_contour_closed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_has_segment,
  output logic [tpsp_pkg::OUT_CI_W-1:0] out_contour_index,
  output logic [tpsp_pkg::DIST_W-1:0]   out_segment_start,
  output logic [tpsp_pkg::DIST_W-1:0]   out_segment_end,
  output logic                          out_start_new,
  output logic                          out_close_after,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpsp_pkg::DATA_W-1:0]   pwdata,
  output logic [tpsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int LEN_W  = tpsp_pkg::LEN_W;
  localparam int DIST_W = tpsp_pkg::DIST_W;
  localparam int FRAC_W = tpsp_pkg::FRAC_W;
  localparam int CI_W   = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam int CNT_W  = $clog2(MAX_CONTOURS + 1);
  localparam int TOT_W  = LEN_W + CNT_W;
  localparam int SW     = (TOT_W + 4 > DIST_W + 2) ? TOT_W + 4 : DIST_W + 2;
  localparam int PC_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int PA_W   = $clog2(MAX_SEGMENTS);
  localparam int PW     = CI_W + 2 * DIST_W + 3;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SUM    = 4'd1;
  localparam logic [3:0] ST_M0     = 4'd2;
  localparam logic [3:0] ST_M1     = 4'd3;
  localparam logic [3:0] ST_M2     = 4'd4;
  localparam logic [3:0] ST_SWAP   = 4'd5;
  localparam logic [3:0] ST_WRAP   = 4'd6;
  localparam logic [3:0] ST_WALK   = 4'd7;
  localparam logic [3:0] ST_YLD    = 4'd8;
  localparam logic [3:0] ST_YREC   = 4'd9;
  localparam logic [3:0] ST_ORD    = 4'd10;
  localparam logic [3:0] ST_OLD    = 4'd11;
  localparam logic [3:0] ST_OEMPTY = 4'd12;
  localparam logic [3:0] ST_OWAIT  = 4'd13;

  // configuration
  logic [FRAC_W-1:0] trim_start_r, trim_end_r;
  logic [31:0]       trim_offset_r;
  logic              trim_mode_r, close_all_r;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_start_r  <= '0;
      trim_end_r    <= tpsp_pkg::FRAC_ONE;
      trim_offset_r <= '0;
      trim_mode_r   <= 1'b0;
      close_all_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        tpsp_pkg::REG_TRIM_START:  trim_start_r  <= pwdata[FRAC_W-1:0];
        tpsp_pkg::REG_TRIM_END:    trim_end_r    <= pwdata[FRAC_W-1:0];
        tpsp_pkg::REG_TRIM_OFFSET: trim_offset_r <= pwdata;
        tpsp_pkg::REG_TRIM_MODE:   trim_mode_r   <= pwdata[0];
        tpsp_pkg::REG_CLOSE_ALL:   close_all_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tpsp_pkg::REG_TRIM_START:  prdata = 32'(trim_start_r);
      tpsp_pkg::REG_TRIM_END:    prdata = 32'(trim_end_r);
      tpsp_pkg::REG_TRIM_OFFSET: prdata = trim_offset_r;
      tpsp_pkg::REG_TRIM_MODE:   prdata = 32'(trim_mode_r);
      tpsp_pkg::REG_CLOSE_ALL:   prdata = 32'(close_all_r);
      default:                   prdata = '0;
    endcase
  end

  // sequencer registers
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ci_r, ci_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic signed [SW-1:0] s_r, s_nxt, e_r, e_nxt;
  logic              nw_r, nw_nxt;
  logic [PC_W-1:0]   pcnt_r, pcnt_nxt;
  logic [PC_W-1:0]   k_r, k_nxt;
  logic [CI_W-1:0]   prev_ci_r, prev_ci_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_has_r, out_has_nxt;
  logic [tpsp_pkg::OUT_CI_W-1:0] out_ci_r, out_ci_nxt;
  logic [DIST_W-1:0] out_s_r, out_s_nxt, out_e_r, out_e_nxt;
  logic              out_new_r, out_new_nxt;
  logic              out_cl_r, out_cl_nxt;
  logic              out_last_r, out_last_nxt;

  // contour store
  logic [LEN_W-1:0] len_mem_r [MAX_CONTOURS];
  logic             closed_mem_r [MAX_CONTOURS];
  logic             add_we;
  logic [LEN_W-1:0] len_cur;
  logic             closed_cur;
  logic signed [SW-1:0] lenx, totx;

  assign add_we = (state_r == ST_IDLE) && in_valid && (in_op == tpsp_pkg::OP_ADD) &&
                  (count_r < CNT_W'(MAX_CONTOURS));

  always_ff @(posedge clk) begin
    if (add_we) begin
      len_mem_r[count_r[CI_W-1:0]]    <= in_contour_length;
      closed_mem_r[count_r[CI_W-1:0]] <= in_contour_closed;
    end
  end

  assign len_cur    = len_mem_r[ci_r[CI_W-1:0]];
  assign closed_cur = closed_mem_r[ci_r[CI_W-1:0]];
  assign lenx       = $signed(SW'(len_cur));
  assign totx       = $signed(SW'(total_r));

  // shared scaling unit
  logic [TOT_W-1:0]  mul_a;
  logic [FRAC_W-1:0] mul_f;
  logic [TOT_W+1:0]  mul_q;

  assign mul_a = (trim_mode_r == tpsp_pkg::MODE_SEQ) ? total_r : TOT_W'(len_cur);
  assign mul_f = (state_r == ST_M1) ? trim_end_r : trim_start_r;

  tpsp_mul #(.A_W(TOT_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .frac (mul_f),
    .off  (trim_offset_r[tpsp_pkg::OFF_W-1:0]),
    .q    (mul_q)
  );

  // segment plan
  logic            plan_we;
  logic [PA_W-1:0] plan_waddr, plan_raddr;
  logic [PW-1:0]   plan_wdata, plan_rdata;
  logic            rec_close, rec_new;
  logic [PC_W-1:0] rd_idx;

  function automatic logic [DIST_W-1:0] sat_dist(input logic signed [SW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(SW'(tpsp_pkg::DIST_MAX))) begin
      return tpsp_pkg::DIST_MAX;
    end else begin
      return v[DIST_W-1:0];
    end
  endfunction

  assign plan_waddr = pcnt_r[PA_W-1:0];
  assign plan_wdata = {ci_r[CI_W-1:0], sat_dist(s_r), sat_dist(e_r),
                       rec_close, closed_cur, rec_new};
  assign rd_idx     = (trim_mode_r != tpsp_pkg::MODE_SEQ || k_r == '0) ? k_r : pcnt_r - k_r;
  assign plan_raddr = rd_idx[PA_W-1:0];

  tpsp_ram #(.WIDTH(PW), .DEPTH(MAX_SEGMENTS)) u_plan (
    .clk   (clk),
    .we    (plan_we),
    .waddr (plan_waddr),
    .wdata (plan_wdata),
    .raddr (plan_raddr),
    .rdata (plan_rdata)
  );

  logic [CI_W-1:0] rd_ci;
  logic            rd_close, rd_cclosed, rd_new;
  logic            plan_full, closing_sync, more;
  logic [3:0]      out_start_state;

  assign rd_ci      = plan_rdata[PW-1 -: CI_W];
  assign rd_close   = plan_rdata[2];
  assign rd_cclosed = plan_rdata[1];
  assign rd_new     = plan_rdata[0];
  assign plan_full  = (pcnt_r == PC_W'(MAX_SEGMENTS));
  assign closing_sync = (trim_start_r == '0 && trim_end_r == tpsp_pkg::FRAC_ONE && closed_cur)
                        || close_all_r;
  assign more = (e_r > lenx);
  assign out_start_state = (pcnt_r == '0) ? ST_OEMPTY : ST_ORD;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ci_nxt        = ci_r;
    total_nxt     = total_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    nw_nxt        = nw_r;
    pcnt_nxt      = pcnt_r;
    k_nxt         = k_r;
    prev_ci_nxt   = prev_ci_r;
    out_valid_nxt = out_valid_r;
    out_has_nxt   = out_has_r;
    out_ci_nxt    = out_ci_r;
    out_s_nxt     = out_s_r;
    out_e_nxt     = out_e_r;
    out_new_nxt   = out_new_r;
    out_cl_nxt    = out_cl_r;
    out_last_nxt  = out_last_r;
    plan_we       = 1'b0;
    rec_close     = 1'b0;
    rec_new       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            tpsp_pkg::OP_CLEAR: count_nxt = '0;
            tpsp_pkg::OP_ADD: begin
              if (add_we) count_nxt = count_r + 1'b1;
            end
            tpsp_pkg::OP_RUN: begin
              pcnt_nxt  = '0;
              ci_nxt    = '0;
              total_nxt = '0;
              state_nxt = (trim_mode_r == tpsp_pkg::MODE_SEQ) ? ST_SUM : ST_YLD;
            end
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        if (ci_r == count_r) begin
          state_nxt = ST_M0;
        end else begin
          total_nxt = total_r + TOT_W'(len_cur);
          ci_nxt    = ci_r + 1'b1;
        end
      end
      ST_M0: state_nxt = ST_M1;
      ST_M1: begin
        s_nxt     = $signed(SW'(mul_q));
        state_nxt = ST_M2;
      end
      ST_M2: begin
        e_nxt     = $signed(SW'(mul_q));
        state_nxt = ST_SWAP;
      end
      ST_SWAP: begin
        if (e_r < s_r) begin
          s_nxt = e_r;
          e_nxt = s_r;
        end
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        nw_nxt = 1'b1;
        if (trim_mode_r == tpsp_pkg::MODE_SEQ) begin
          ci_nxt = '0;
          if (s_r > totx) begin
            s_nxt = s_r - totx;
            e_nxt = e_r - totx;
          end
          state_nxt = ST_WALK;
        end else begin
          if (s_r >= lenx) begin
            s_nxt = s_r - lenx;
            e_nxt = e_r - lenx;
          end
          state_nxt = ST_YREC;
        end
      end
      ST_WALK: begin
        if (e_r <= 0 || plan_full) begin
          k_nxt     = '0;
          state_nxt = out_start_state;
        end else begin
          if (s_r < lenx) begin
            rec_close = (s_r == 0 && e_r >= lenx && closed_cur) || close_all_r;
            plan_we   = 1'b1;
            pcnt_nxt  = pcnt_r + 1'b1;
            e_nxt     = e_r - lenx;
            s_nxt     = '0;
          end else begin
            s_nxt = s_r - lenx;
            e_nxt = e_r - lenx;
          end
          ci_nxt = (ci_r + 1'b1 == count_r) ? '0 : ci_r + 1'b1;
        end
      end
      ST_YLD: begin
        if (ci_r == count_r) begin
          k_nxt     = '0;
          state_nxt = out_start_state;
        end else begin
          state_nxt = ST_M0;
        end
      end
      ST_YREC: begin
        if (plan_full) begin
          k_nxt     = '0;
          state_nxt = out_start_state;
        end else begin
          rec_close = closing_sync && !more;
          rec_new   = nw_r;
          plan_we   = 1'b1;
          pcnt_nxt  = pcnt_r + 1'b1;
          if (more) begin
            s_nxt  = '0;
            e_nxt  = e_r - lenx;
            nw_nxt = !closed_cur;
          end else begin
            ci_nxt    = ci_r + 1'b1;
            state_nxt = ST_YLD;
          end
        end
      end
      ST_ORD: state_nxt = ST_OLD;
      ST_OLD: begin
        out_valid_nxt = 1'b1;
        out_has_nxt   = 1'b1;
        out_ci_nxt    = tpsp_pkg::OUT_CI_W'(rd_ci);
        out_s_nxt     = plan_rdata[PW-CI_W-1 -: DIST_W];
        out_e_nxt     = plan_rdata[PW-CI_W-DIST_W-1 -: DIST_W];
        out_cl_nxt    = rd_close;
        // sequential emission order 0, then p-1 down to 1 (p = plan count): join only same closed contour
        out_new_nxt   = (trim_mode_r != tpsp_pkg::MODE_SEQ) ? rd_new :
                        (k_r == '0 || rd_ci != prev_ci_r || !rd_cclosed);
        out_last_nxt  = (k_r + 1'b1 == pcnt_r);
        prev_ci_nxt   = rd_ci;
        state_nxt     = ST_OWAIT;
      end
      ST_OEMPTY: begin
        out_valid_nxt = 1'b1;
        out_has_nxt   = 1'b0;
        out_ci_nxt    = '0;
        out_s_nxt     = '0;
        out_e_nxt     = '0;
        out_new_nxt   = 1'b0;
        out_cl_nxt    = 1'b0;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_ORD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pcnt_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pcnt_r      <= pcnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ci_r       <= ci_nxt;
    total_r    <= total_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    nw_r       <= nw_nxt;
    prev_ci_r  <= prev_ci_nxt;
    out_has_r  <= out_has_nxt;
    out_ci_r   <= out_ci_nxt;
    out_s_r    <= out_s_nxt;
    out_e_r    <= out_e_nxt;
    out_new_r  <= out_new_nxt;
    out_cl_r   <= out_cl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_has_segment   = out_has_r;
  assign out_contour_index = out_ci_r;
  assign out_segment_start = out_s_r;
  assign out_segment_end   = out_e_r;
  assign out_start_new     = out_new_r;
  assign out_close_after   = out_cl_r;
  assign out_last          = out_last_r;

  // checks
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !in_stall)
    else $error("block not idle after last transfer");

  a_plan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PC_W'(MAX_SEGMENTS))
    else $error("plan count beyond capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CONTOURS))
    else $error("contour count beyond capacity");

endmodule
